>>> design/gjk_pkg.sv
// Package for the 2D simplex closest-point block.
// Holds the widths, the request and response payload types and the inter-stage types.
`timescale 1ns / 1ps

package gjk_pkg;

   // Field widths of the payload.
   localparam int COORD_BITS  = 16;
   localparam int WEIGHT_BITS = 16;

   // Coordinates are taken from their low CW bits.
   localparam int CW = (COORD_BITS < 30) ? COORD_BITS : 30;
   // Width of one coordinate product.
   localparam int PP = 2 * CW + 2;
   // Width of a dot or cross product sum, and of a weight denominator.
   localparam int PW = 2 * CW + 5;
   // Number of products formed for one simplex.
   localparam int NPROD = 20;

   typedef struct packed {
      logic [1:0]                   point_count;
      logic signed [COORD_BITS-1:0] first_x;
      logic signed [COORD_BITS-1:0] first_y;
      logic signed [COORD_BITS-1:0] second_x;
      logic signed [COORD_BITS-1:0] second_y;
      logic signed [COORD_BITS-1:0] third_x;
      logic signed [COORD_BITS-1:0] third_y;
   } req_type;

   typedef struct packed {
      logic [1:0]                   kept_count;
      logic signed [COORD_BITS-1:0] out_first_x;
      logic signed [COORD_BITS-1:0] out_first_y;
      logic signed [COORD_BITS-1:0] out_second_x;
      logic signed [COORD_BITS-1:0] out_second_y;
      logic signed [COORD_BITS-1:0] out_third_x;
      logic signed [COORD_BITS-1:0] out_third_y;
      logic [WEIGHT_BITS-1:0]       weight_first;
      logic [WEIGHT_BITS-1:0]       weight_second;
      logic                         degenerate;
   } rsp_type;

   // Sums of products, with the points, after the product stages.
   typedef struct packed {
      logic                 cnt3;
      logic signed [CW-1:0] x1;
      logic signed [CW-1:0] y1;
      logic signed [CW-1:0] x2;
      logic signed [CW-1:0] y2;
      logic signed [CW-1:0] x3;
      logic signed [CW-1:0] y3;
      logic signed [PW-1:0] d12_1;
      logic signed [PW-1:0] d12_2;
      logic signed [PW-1:0] d13_1;
      logic signed [PW-1:0] d13_2;
      logic signed [PW-1:0] d23_1;
      logic signed [PW-1:0] d23_2;
      logic signed [PW-1:0] n;
      logic signed [PW-1:0] c1;
      logic signed [PW-1:0] c2;
      logic signed [PW-1:0] c3;
   } sums_type;

   // Result fields that ride alongside the weight divider.
   typedef struct packed {
      logic [1:0]           kept_count;
      logic signed [CW-1:0] o1x;
      logic signed [CW-1:0] o1y;
      logic signed [CW-1:0] o2x;
      logic signed [CW-1:0] o2y;
      logic signed [CW-1:0] o3x;
      logic signed [CW-1:0] o3y;
      logic                 degenerate;
   } side_type;

   // Region decision handed to the weight divider.
   typedef struct packed {
      side_type             side;
      logic                 force_max;
      logic                 neg;
      logic signed [PW-1:0] num_a;
      logic signed [PW-1:0] den_a;
      logic signed [PW-1:0] num_b;
      logic signed [PW-1:0] den_b;
   } region_type;

endpackage

>>> design/gjk_2d_simplex_closest_point.sv
// Top level of the 2D simplex closest-point block.
// Depends on gjk_pkg, gjk_prod, gjk_region and gjk_div.
`timescale 1ns / 1ps

// Usage:
// A request carries a segment (point_count other than 3) or a triangle
// (point_count 3) of signed Q8.8 points. Every request gives one response
// with the kept point count, the kept points, the third point passed
// through, the Q0.16 weights and the degenerate flag.
// Both channels use valid and stall; a request moves on an edge where
// valid is high and stall is low.
// A request passes three product stages, one region stage, two divider
// setup stages, one stage per quotient bit and one output stage on its way
// to the response.
// Throughput is one request per cycle while rsp_stall is low; every stage
// holds a valid bit and takes new data whenever it is empty or its contents
// move on, so bubbles close up while the receiver stalls.
// When rsp_stall is held, the response stays stable and the pipeline fills
// up behind it before req_stall is raised.
// Reset clears all valid bits; the block keeps no other state.

module gjk_2d_simplex_closest_point
   import gjk_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic                   prod_ready;
   logic                   sums_valid, sums_ready;
   sums_type               sums;
   logic                   region_valid, region_ready;
   region_type             region;
   side_type               side;
   logic [WEIGHT_BITS-1:0] weight_a, weight_b;

   gjk_prod u_prod (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (prod_ready),
      .in_data   (req_payload),
      .out_valid (sums_valid),
      .out_ready (sums_ready),
      .out_data  (sums)
   );

   gjk_region u_region (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sums_valid),
      .in_ready  (sums_ready),
      .in_data   (sums),
      .out_valid (region_valid),
      .out_ready (region_ready),
      .out_data  (region)
   );

   gjk_div u_div (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (region_valid),
      .in_ready     (region_ready),
      .in_data      (region),
      .out_valid    (rsp_valid),
      .out_ready    (!rsp_stall),
      .out_side     (side),
      .out_weight_a (weight_a),
      .out_weight_b (weight_b)
   );

   assign req_stall = !prod_ready;

   // Response fields, coordinates sign-extended to the port width.
   always_comb begin
      rsp_payload.kept_count    = side.kept_count;
      rsp_payload.out_first_x   = COORD_BITS'(side.o1x);
      rsp_payload.out_first_y   = COORD_BITS'(side.o1y);
      rsp_payload.out_second_x  = COORD_BITS'(side.o2x);
      rsp_payload.out_second_y  = COORD_BITS'(side.o2y);
      rsp_payload.out_third_x   = COORD_BITS'(side.o3x);
      rsp_payload.out_third_y   = COORD_BITS'(side.o3y);
      rsp_payload.weight_first  = weight_a;
      rsp_payload.weight_second = weight_b;
      rsp_payload.degenerate    = side.degenerate;
   end

endmodule

>>> design/gjk_prod.sv
// Product stages: point differences, coordinate products and their sums.
// Depends on gjk_pkg.
`timescale 1ns / 1ps

module gjk_prod
   import gjk_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  req_type  in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output sums_type out_data
);

   logic                   a_v_ff, b_v_ff, c_v_ff;
   logic                   a_rdy, b_rdy, c_rdy;
   logic signed [CW-1:0]   a_x_ff [3];
   logic signed [CW-1:0]   a_y_ff [3];
   logic signed [CW:0]     a_ex_ff [3];
   logic signed [CW:0]     a_ey_ff [3];
   logic                   a_cnt3_ff;
   logic signed [CW-1:0]   px_in [3];
   logic signed [CW-1:0]   py_in [3];
   logic signed [PP-1:0]   opa [NPROD];
   logic signed [PP-1:0]   opb [NPROD];
   logic signed [PP-1:0]   b_p_in [NPROD];
   logic signed [PP-1:0]   b_p_ff [NPROD];
   logic signed [CW-1:0]   b_x_ff [3];
   logic signed [CW-1:0]   b_y_ff [3];
   logic                   b_cnt3_ff;
   sums_type               c_in;
   sums_type               c_ff;

   // Stage ready chain: a stage takes new data when empty or when it moves on.
   assign c_rdy    = !c_v_ff || out_ready;
   assign b_rdy    = !b_v_ff || c_rdy;
   assign a_rdy    = !a_v_ff || b_rdy;
   assign in_ready = a_rdy;

   // Coordinates are taken from their low CW bits.
   always_comb begin
      px_in[0] = in_data.first_x[CW-1:0];
      py_in[0] = in_data.first_y[CW-1:0];
      px_in[1] = in_data.second_x[CW-1:0];
      py_in[1] = in_data.second_y[CW-1:0];
      px_in[2] = in_data.third_x[CW-1:0];
      py_in[2] = in_data.third_y[CW-1:0];
   end

   // Stage A: points and edge vectors e12, e13, e23.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (a_rdy) begin
         a_v_ff <= in_valid;
      end
      if (a_rdy) begin
         for (int i = 0; i < 3; i++) begin
            a_x_ff[i] <= px_in[i];
            a_y_ff[i] <= py_in[i];
         end
         a_ex_ff[0] <= (CW+1)'(px_in[1]) - (CW+1)'(px_in[0]);
         a_ey_ff[0] <= (CW+1)'(py_in[1]) - (CW+1)'(py_in[0]);
         a_ex_ff[1] <= (CW+1)'(px_in[2]) - (CW+1)'(px_in[0]);
         a_ey_ff[1] <= (CW+1)'(py_in[2]) - (CW+1)'(py_in[0]);
         a_ex_ff[2] <= (CW+1)'(px_in[2]) - (CW+1)'(px_in[1]);
         a_ey_ff[2] <= (CW+1)'(py_in[2]) - (CW+1)'(py_in[1]);
         a_cnt3_ff  <= (in_data.point_count == 2'd3);
      end
   end

   // Operand pairs of every product the region tests need.
   always_comb begin
      opa[0]  = PP'(a_x_ff[1]);  opb[0]  = PP'(a_ex_ff[0]);
      opa[1]  = PP'(a_y_ff[1]);  opb[1]  = PP'(a_ey_ff[0]);
      opa[2]  = PP'(a_x_ff[0]);  opb[2]  = PP'(a_ex_ff[0]);
      opa[3]  = PP'(a_y_ff[0]);  opb[3]  = PP'(a_ey_ff[0]);
      opa[4]  = PP'(a_x_ff[2]);  opb[4]  = PP'(a_ex_ff[1]);
      opa[5]  = PP'(a_y_ff[2]);  opb[5]  = PP'(a_ey_ff[1]);
      opa[6]  = PP'(a_x_ff[0]);  opb[6]  = PP'(a_ex_ff[1]);
      opa[7]  = PP'(a_y_ff[0]);  opb[7]  = PP'(a_ey_ff[1]);
      opa[8]  = PP'(a_x_ff[2]);  opb[8]  = PP'(a_ex_ff[2]);
      opa[9]  = PP'(a_y_ff[2]);  opb[9]  = PP'(a_ey_ff[2]);
      opa[10] = PP'(a_x_ff[1]);  opb[10] = PP'(a_ex_ff[2]);
      opa[11] = PP'(a_y_ff[1]);  opb[11] = PP'(a_ey_ff[2]);
      opa[12] = PP'(a_ex_ff[0]); opb[12] = PP'(a_ey_ff[1]);
      opa[13] = PP'(a_ey_ff[0]); opb[13] = PP'(a_ex_ff[1]);
      opa[14] = PP'(a_x_ff[1]);  opb[14] = PP'(a_y_ff[2]);
      opa[15] = PP'(a_y_ff[1]);  opb[15] = PP'(a_x_ff[2]);
      opa[16] = PP'(a_x_ff[2]);  opb[16] = PP'(a_y_ff[0]);
      opa[17] = PP'(a_y_ff[2]);  opb[17] = PP'(a_x_ff[0]);
      opa[18] = PP'(a_x_ff[0]);  opb[18] = PP'(a_y_ff[1]);
      opa[19] = PP'(a_y_ff[0]);  opb[19] = PP'(a_x_ff[1]);
      for (int i = 0; i < NPROD; i++) begin
         b_p_in[i] = opa[i] * opb[i];
      end
   end

   // Stage B: registered products.
   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (b_rdy) begin
         b_v_ff <= a_v_ff;
      end
      if (b_rdy) begin
         for (int i = 0; i < NPROD; i++) begin
            b_p_ff[i] <= b_p_in[i];
         end
         for (int i = 0; i < 3; i++) begin
            b_x_ff[i] <= a_x_ff[i];
            b_y_ff[i] <= a_y_ff[i];
         end
         b_cnt3_ff <= a_cnt3_ff;
      end
   end

   // Dot and cross products from the product pairs.
   always_comb begin
      c_in.cnt3  = b_cnt3_ff;
      c_in.x1    = b_x_ff[0];
      c_in.y1    = b_y_ff[0];
      c_in.x2    = b_x_ff[1];
      c_in.y2    = b_y_ff[1];
      c_in.x3    = b_x_ff[2];
      c_in.y3    = b_y_ff[2];
      c_in.d12_1 = PW'(b_p_ff[0]) + PW'(b_p_ff[1]);
      c_in.d12_2 = -PW'(b_p_ff[2]) - PW'(b_p_ff[3]);
      c_in.d13_1 = PW'(b_p_ff[4]) + PW'(b_p_ff[5]);
      c_in.d13_2 = -PW'(b_p_ff[6]) - PW'(b_p_ff[7]);
      c_in.d23_1 = PW'(b_p_ff[8]) + PW'(b_p_ff[9]);
      c_in.d23_2 = -PW'(b_p_ff[10]) - PW'(b_p_ff[11]);
      c_in.n     = PW'(b_p_ff[12]) - PW'(b_p_ff[13]);
      c_in.c1    = PW'(b_p_ff[14]) - PW'(b_p_ff[15]);
      c_in.c2    = PW'(b_p_ff[16]) - PW'(b_p_ff[17]);
      c_in.c3    = PW'(b_p_ff[18]) - PW'(b_p_ff[19]);
   end

   // Stage C: registered sums.
   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
      end else if (c_rdy) begin
         c_v_ff <= b_v_ff;
      end
      if (c_rdy) begin
         c_ff <= c_in;
      end
   end

   assign out_valid = c_v_ff;
   assign out_data  = c_ff;

endmodule

>>> design/gjk_region.sv
// Region stage: picks the vertex, edge or interior region and the weight ratios.
// Depends on gjk_pkg.
`timescale 1ns / 1ps

module gjk_region
   import gjk_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  sums_type   in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output region_type out_data
);

   logic       v_ff;
   logic       rdy;
   region_type r_in;
   region_type r_ff;

   function automatic logic nonpos_prod(logic signed [PW-1:0] a, logic signed [PW-1:0] b);
      return (a == '0) || (b == '0) || (a[PW-1] != b[PW-1]);
   endfunction

   assign rdy      = !v_ff || out_ready;
   assign in_ready = rdy;

   // Region tests, in the order the solver tries them.
   always_comb begin
      r_in.side.kept_count = 2'd1;
      r_in.side.o1x        = in_data.x1;
      r_in.side.o1y        = in_data.y1;
      r_in.side.o2x        = in_data.x2;
      r_in.side.o2y        = in_data.y2;
      r_in.side.o3x        = in_data.x3;
      r_in.side.o3y        = in_data.y3;
      r_in.side.degenerate = 1'b0;
      r_in.force_max       = 1'b0;
      r_in.neg             = 1'b0;
      r_in.num_a           = '0;
      r_in.den_a           = '0;
      r_in.num_b           = '0;
      r_in.den_b           = '0;
      if (!in_data.cnt3) begin
         // Segment solve.
         if (in_data.d12_2 <= 0) begin
            r_in.force_max = 1'b1;
         end else if (in_data.d12_1 <= 0) begin
            r_in.side.o1x  = in_data.x2;
            r_in.side.o1y  = in_data.y2;
            r_in.force_max = 1'b1;
         end else begin
            r_in.side.kept_count = 2'd2;
            r_in.num_a = in_data.d12_1;
            r_in.den_a = in_data.d12_1 + in_data.d12_2;
         end
      end else begin
         // Triangle solve.
         if (in_data.d12_2 <= 0 && in_data.d13_2 <= 0) begin
            r_in.force_max = 1'b1;
         end else if (in_data.d12_1 > 0 && in_data.d12_2 > 0 &&
                      nonpos_prod(in_data.n, in_data.c3)) begin
            r_in.side.kept_count = 2'd2;
            r_in.num_a = in_data.d12_1;
            r_in.den_a = in_data.d12_1 + in_data.d12_2;
         end else if (in_data.d13_1 > 0 && in_data.d13_2 > 0 &&
                      nonpos_prod(in_data.n, in_data.c2)) begin
            r_in.side.kept_count = 2'd2;
            r_in.side.o2x = in_data.x3;
            r_in.side.o2y = in_data.y3;
            r_in.num_a = in_data.d13_1;
            r_in.den_a = in_data.d13_1 + in_data.d13_2;
         end else if (in_data.d12_1 <= 0 && in_data.d23_2 <= 0) begin
            r_in.side.o1x  = in_data.x2;
            r_in.side.o1y  = in_data.y2;
            r_in.force_max = 1'b1;
         end else if (in_data.d13_1 <= 0 && in_data.d23_1 <= 0) begin
            r_in.side.o1x  = in_data.x3;
            r_in.side.o1y  = in_data.y3;
            r_in.force_max = 1'b1;
         end else if (in_data.d23_1 > 0 && in_data.d23_2 > 0 &&
                      nonpos_prod(in_data.n, in_data.c1)) begin
            r_in.side.kept_count = 2'd2;
            r_in.side.o1x = in_data.x3;
            r_in.side.o1y = in_data.y3;
            r_in.num_a = in_data.d23_2;
            r_in.den_a = in_data.d23_1 + in_data.d23_2;
         end else begin
            // Interior; a zero area leaves both weights at zero.
            r_in.side.kept_count = 2'd3;
            if (in_data.n == '0) begin
               r_in.side.degenerate = 1'b1;
            end else begin
               r_in.neg   = in_data.n[PW-1];
               r_in.num_a = in_data.c1;
               r_in.den_a = in_data.n;
               r_in.num_b = in_data.c2;
               r_in.den_b = in_data.n;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (rdy) begin
         v_ff <= in_valid;
      end
      if (rdy) begin
         r_ff <= r_in;
      end
   end

   assign out_valid = v_ff;
   assign out_data  = r_ff;

endmodule

>>> design/gjk_div.sv
// Pipelined restoring divider for the two weights, one quotient bit per stage.
// Depends on gjk_pkg.
`timescale 1ns / 1ps

module gjk_div
   import gjk_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  region_type             in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output side_type               out_side,
   output logic [WEIGHT_BITS-1:0] out_weight_a,
   output logic [WEIGHT_BITS-1:0] out_weight_b
);

   localparam int NST = WEIGHT_BITS;

   // Negate stage.
   logic                   n_v_ff, n_rdy;
   side_type               n_side_ff;
   logic                   n_force_ff;
   logic signed [PW-1:0]   n_num_ff [2];
   logic signed [PW-1:0]   n_den_ff [2];
   // Range check stage.
   logic                   k_v_ff, k_rdy;
   side_type               k_side_ff;
   logic                   k_zero_ff [2];
   logic                   k_sat_ff [2];
   logic [PW-1:0]          k_r_ff [2];
   logic [PW-1:0]          k_d_ff [2];
   // Quotient bit stages.
   logic                   s_v_ff [NST];
   logic                   s_rdy [NST];
   side_type               s_side_ff [NST];
   logic                   s_zero_ff [NST][2];
   logic                   s_sat_ff [NST][2];
   logic [PW-1:0]          s_r_ff [NST][2];
   logic [PW-1:0]          s_d_ff [NST][2];
   logic [WEIGHT_BITS-1:0] s_q_ff [NST][2];
   logic                   src_v [NST];
   side_type               src_side [NST];
   logic                   src_zero [NST][2];
   logic                   src_sat [NST][2];
   logic [PW-1:0]          src_r [NST][2];
   logic [PW-1:0]          src_d [NST][2];
   logic [WEIGHT_BITS-1:0] src_q [NST][2];
   logic [PW-1:0]          s_r_in [NST][2];
   logic [WEIGHT_BITS-1:0] s_q_in [NST][2];
   logic [PW:0]            shifted [NST][2];
   // Output stage.
   logic                   f_v_ff, f_rdy;
   side_type               f_side_ff;
   logic [WEIGHT_BITS-1:0] f_w_ff [2];

   // Ready chain from the output back to the input.
   always_comb begin
      f_rdy = !f_v_ff || out_ready;
      s_rdy[NST-1] = !s_v_ff[NST-1] || f_rdy;
      for (int s = NST - 2; s >= 0; s--) begin
         s_rdy[s] = !s_v_ff[s] || s_rdy[s+1];
      end
      k_rdy = !k_v_ff || s_rdy[0];
      n_rdy = !n_v_ff || k_rdy;
   end

   assign in_ready = n_rdy;

   // A negative area flips the signs of both numerators and both denominators.
   always_ff @(posedge clock) begin
      if (reset) begin
         n_v_ff <= 1'b0;
      end else if (n_rdy) begin
         n_v_ff <= in_valid;
      end
      if (n_rdy) begin
         n_side_ff   <= in_data.side;
         n_force_ff  <= in_data.force_max;
         n_num_ff[0] <= in_data.neg ? -in_data.num_a : in_data.num_a;
         n_den_ff[0] <= in_data.neg ? -in_data.den_a : in_data.den_a;
         n_num_ff[1] <= in_data.neg ? -in_data.num_b : in_data.num_b;
         n_den_ff[1] <= in_data.neg ? -in_data.den_b : in_data.den_b;
      end
   end

   // Num or den at or below zero gives zero; a ratio at or above one saturates.
   // A vertex result forces the first weight to its full value.
   always_ff @(posedge clock) begin
      if (reset) begin
         k_v_ff <= 1'b0;
      end else if (k_rdy) begin
         k_v_ff <= n_v_ff;
      end
      if (k_rdy) begin
         k_side_ff <= n_side_ff;
         for (int l = 0; l < 2; l++) begin
            k_zero_ff[l] <= !(l == 0 && n_force_ff) &&
                            ((n_den_ff[l] <= 0) || (n_num_ff[l] <= 0));
            k_sat_ff[l]  <= (l == 0 && n_force_ff) || (n_num_ff[l] >= n_den_ff[l]);
            k_r_ff[l]    <= n_num_ff[l];
            k_d_ff[l]    <= n_den_ff[l];
         end
      end
   end

   // Source of each quotient stage: the check stage or the stage before.
   always_comb begin
      src_v[0]    = k_v_ff;
      src_side[0] = k_side_ff;
      for (int l = 0; l < 2; l++) begin
         src_zero[0][l] = k_zero_ff[l];
         src_sat[0][l]  = k_sat_ff[l];
         src_r[0][l]    = k_r_ff[l];
         src_d[0][l]    = k_d_ff[l];
         src_q[0][l]    = '0;
      end
      for (int s = 1; s < NST; s++) begin
         src_v[s]    = s_v_ff[s-1];
         src_side[s] = s_side_ff[s-1];
         for (int l = 0; l < 2; l++) begin
            src_zero[s][l] = s_zero_ff[s-1][l];
            src_sat[s][l]  = s_sat_ff[s-1][l];
            src_r[s][l]    = s_r_ff[s-1][l];
            src_d[s][l]    = s_d_ff[s-1][l];
            src_q[s][l]    = s_q_ff[s-1][l];
         end
      end
   end

   // One restoring step: shift the remainder, subtract when it fits.
   always_comb begin
      for (int s = 0; s < NST; s++) begin
         for (int l = 0; l < 2; l++) begin
            shifted[s][l] = {src_r[s][l], 1'b0};
            if (shifted[s][l] >= {1'b0, src_d[s][l]}) begin
               s_r_in[s][l] = PW'(shifted[s][l] - {1'b0, src_d[s][l]});
               s_q_in[s][l] = {src_q[s][l][WEIGHT_BITS-2:0], 1'b1};
            end else begin
               s_r_in[s][l] = shifted[s][l][PW-1:0];
               s_q_in[s][l] = {src_q[s][l][WEIGHT_BITS-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < NST; s++) begin
         if (reset) begin
            s_v_ff[s] <= 1'b0;
         end else if (s_rdy[s]) begin
            s_v_ff[s] <= src_v[s];
         end
         if (s_rdy[s]) begin
            s_side_ff[s] <= src_side[s];
            for (int l = 0; l < 2; l++) begin
               s_zero_ff[s][l] <= src_zero[s][l];
               s_sat_ff[s][l]  <= src_sat[s][l];
               s_r_ff[s][l]    <= s_r_in[s][l];
               s_d_ff[s][l]    <= src_d[s][l];
               s_q_ff[s][l]    <= s_q_in[s][l];
            end
         end
      end
   end

   // Output stage applies zero and saturation.
   always_ff @(posedge clock) begin
      if (reset) begin
         f_v_ff <= 1'b0;
      end else if (f_rdy) begin
         f_v_ff <= s_v_ff[NST-1];
      end
      if (f_rdy) begin
         f_side_ff <= s_side_ff[NST-1];
         for (int l = 0; l < 2; l++) begin
            if (s_zero_ff[NST-1][l]) begin
               f_w_ff[l] <= '0;
            end else if (s_sat_ff[NST-1][l]) begin
               f_w_ff[l] <= '1;
            end else begin
               f_w_ff[l] <= s_q_ff[NST-1][l];
            end
         end
      end
   end

   assign out_valid    = f_v_ff;
   assign out_side     = f_side_ff;
   assign out_weight_a = f_w_ff[0];
   assign out_weight_b = f_w_ff[1];

endmodule

>>> tb/tb_gjk_2d_simplex_closest_point.sv
// Testbench for the 2D simplex closest-point block.
// Depends on gjk_pkg and gjk_2d_simplex_closest_point; predicts each response in-line.
`timescale 1ns / 1ps

module tb_gjk_2d_simplex_closest_point
   import gjk_pkg::*;
();

   localparam int  LATENCY   = WEIGHT_BITS + 7;
   localparam int  N_RANDOM  = 800;
   localparam longint CYCLE_LIMIT = 200000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;

   req_type simplex_queue[$];
   rsp_type region_queue[$];
   int      mismatch_count;
   int      checked_count;
   int      deg_count;
   int      interior_count;
   longint  cycle_count;
   bit      feed_done;
   int      hold_cycles;

   gjk_2d_simplex_closest_point DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
   );

   // Clock; the single reset at the start is driven in its own block.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Weight num/den in Q0.16, clipped at zero and at one.
   function automatic logic [WEIGHT_BITS-1:0] weight_ratio(longint num, longint den);
      longint q;
      if (den <= 0 || num <= 0) return '0;
      if (num >= den) return '1;
      q = (num << WEIGHT_BITS) / den;
      return q[WEIGHT_BITS-1:0];
   endfunction

   function automatic bit sign_disagrees(longint a, longint b);
      return a == 0 || b == 0 || ((a < 0) != (b < 0));
   endfunction

   // Closest-point region of the segment or triangle to the origin.
   function automatic rsp_type solve_simplex(req_type r);
      rsp_type o;
      longint x1, y1, x2, y2, x3, y3;
      longint d12a, d12b, d13a, d13b, d23a, d23b, n, c1, c2, c3;
      x1 = r.first_x;  y1 = r.first_y;
      x2 = r.second_x; y2 = r.second_y;
      x3 = r.third_x;  y3 = r.third_y;
      o = '0;
      o.out_first_x = r.first_x;   o.out_first_y = r.first_y;
      o.out_second_x = r.second_x; o.out_second_y = r.second_y;
      o.out_third_x = r.third_x;   o.out_third_y = r.third_y;
      d12a = x2 * (x2 - x1) + y2 * (y2 - y1);
      d12b = -(x1 * (x2 - x1) + y1 * (y2 - y1));
      if (r.point_count != 2'd3) begin
         if (d12b <= 0) begin
            o.kept_count = 2'd1; o.weight_first = '1;
         end else if (d12a <= 0) begin
            o.out_first_x = r.second_x; o.out_first_y = r.second_y;
            o.kept_count = 2'd1; o.weight_first = '1;
         end else begin
            o.kept_count = 2'd2; o.weight_first = weight_ratio(d12a, d12a + d12b);
         end
         return o;
      end
      d13a = x3 * (x3 - x1) + y3 * (y3 - y1);
      d13b = -(x1 * (x3 - x1) + y1 * (y3 - y1));
      d23a = x3 * (x3 - x2) + y3 * (y3 - y2);
      d23b = -(x2 * (x3 - x2) + y2 * (y3 - y2));
      n  = (x2 - x1) * (y3 - y1) - (y2 - y1) * (x3 - x1);
      c1 = x2 * y3 - y2 * x3;
      c2 = x3 * y1 - y3 * x1;
      c3 = x1 * y2 - y1 * x2;
      if (d12b <= 0 && d13b <= 0) begin
         o.kept_count = 2'd1; o.weight_first = '1;
      end else if (d12a > 0 && d12b > 0 && sign_disagrees(n, c3)) begin
         o.kept_count = 2'd2; o.weight_first = weight_ratio(d12a, d12a + d12b);
      end else if (d13a > 0 && d13b > 0 && sign_disagrees(n, c2)) begin
         o.kept_count = 2'd2; o.weight_first = weight_ratio(d13a, d13a + d13b);
         o.out_second_x = r.third_x; o.out_second_y = r.third_y;
      end else if (d12a <= 0 && d23b <= 0) begin
         o.out_first_x = r.second_x; o.out_first_y = r.second_y;
         o.kept_count = 2'd1; o.weight_first = '1;
      end else if (d13a <= 0 && d23a <= 0) begin
         o.out_first_x = r.third_x; o.out_first_y = r.third_y;
         o.kept_count = 2'd1; o.weight_first = '1;
      end else if (d23a > 0 && d23b > 0 && sign_disagrees(n, c1)) begin
         o.out_first_x = r.third_x; o.out_first_y = r.third_y;
         o.kept_count = 2'd2; o.weight_first = weight_ratio(d23b, d23a + d23b);
      end else begin
         o.kept_count = 2'd3;
         if (n == 0) o.degenerate = 1'b1;
         else if (n > 0) begin
            o.weight_first = weight_ratio(c1, n); o.weight_second = weight_ratio(c2, n);
         end else begin
            o.weight_first = weight_ratio(-c1, -n); o.weight_second = weight_ratio(-c2, -n);
         end
      end
      return o;
   endfunction

   function automatic logic [15:0] rand_coord(int mode);
      case (mode)
         0: return 16'($urandom);
         1: return 16'($signed($urandom_range(0, 1023)) - 512);
         default: return 16'($signed($urandom_range(0, 16383)) - 8192);
      endcase
   endfunction

   task automatic push_simplex(logic [1:0] cnt, logic [15:0] ax, logic [15:0] ay,
                               logic [15:0] bx, logic [15:0] by,
                               logic [15:0] cx, logic [15:0] cy);
      req_type r;
      r.point_count = cnt;
      r.first_x = ax;  r.first_y = ay;
      r.second_x = bx; r.second_y = by;
      r.third_x = cx;  r.third_y = cy;
      simplex_queue.push_back(r);
   endtask

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch on %s at response %0d: got %0h want %0h",
               field, checked_count, got, want);
      mismatch_count++;
   endtask

   // Stimulus: directed corner cases, then random simplices.
   initial begin
      int mode;
      int k;
      logic [15:0] s;
      mismatch_count = 0;
      checked_count = 0;
      feed_done = 1'b0;
      // Extremes and the segment count codes 0, 1 and 2.
      push_simplex(2'd0, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h0, 16'h0);
      push_simplex(2'd1, 16'h0100, 16'h0100, 16'h0200, 16'h0300, 16'hffff, 16'hffff);
      push_simplex(2'd2, 16'hff00, 16'h0000, 16'h0100, 16'h0000, 16'h1234, 16'h5678);
      push_simplex(2'd2, 16'h0100, 16'h0000, 16'hff00, 16'h0000, 16'h0, 16'h0);
      push_simplex(2'd2, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0, 16'h0);
      // Triangle around the origin: interior.
      push_simplex(2'd3, 16'hff00, 16'hff00, 16'h0100, 16'hff00, 16'h0000, 16'h0100);
      push_simplex(2'd3, 16'hff00, 16'hff00, 16'h0000, 16'h0100, 16'h0100, 16'hff00);
      // Collinear triangle through the origin, and an all-zero triangle.
      push_simplex(2'd3, 16'hff00, 16'hff00, 16'h0100, 16'h0100, 16'h0200, 16'h0200);
      push_simplex(2'd3, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      // Vertex regions and the edge that moves the third point.
      push_simplex(2'd3, 16'h0100, 16'h0100, 16'h0300, 16'h0100, 16'h0100, 16'h0300);
      push_simplex(2'd3, 16'h0300, 16'h0100, 16'h0100, 16'h0100, 16'h0100, 16'h0300);
      push_simplex(2'd3, 16'h0300, 16'h0300, 16'h0300, 16'h0100, 16'h0100, 16'h0100);
      push_simplex(2'd3, 16'hff00, 16'h0100, 16'h0300, 16'h0300, 16'h0100, 16'h0100);
      push_simplex(2'd3, 16'h0300, 16'h0300, 16'hff00, 16'h0100, 16'h0100, 16'hff00);
      push_simplex(2'd3, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
      push_simplex(2'd3, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
      push_simplex(2'd3, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
      // Random part: mostly triangles near the origin, some full-range.
      for (int i = 0; i < N_RANDOM; i++) begin
         mode = $urandom_range(0, 2);
         k = $urandom_range(0, 9);
         if (k == 0) begin
            // Collinear: three points on one line through a random point.
            s = rand_coord(1);
            push_simplex(2'd3, s, s, 16'(s + 16'h40), 16'(s + 16'h40),
                         16'(s + 16'h90), 16'(s + 16'h90));
         end else begin
            push_simplex(k < 7 ? 2'd3 : 2'($urandom_range(0, 2)),
                         rand_coord(mode), rand_coord(mode), rand_coord(mode),
                         rand_coord(mode), rand_coord(mode), rand_coord(mode));
         end
      end
      feed_done = 1'b1;
   end

   // Reset asserted at the start, released at a falling edge.
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   // Acceptance seen at the rising edge, used by the driver at the next falling edge.
   logic req_taken;
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && !req_stall;
   end

   // Driver: one assignment per signal per falling edge.
   int burst_left;
   int gap_left;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_taken) begin
            // Still stalled: hold the payload.
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (simplex_queue.size() > 0) begin
            req_payload <= simplex_queue.pop_front();
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Expected responses are predicted as requests are accepted.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         region_queue.push_back(solve_simplex(req_payload));
         if (solve_simplex(req_payload).degenerate) deg_count++;
         if (solve_simplex(req_payload).kept_count == 2'd3) interior_count++;
      end
   end

   // Receiver stall pattern, with one long hold-off early in the run.
   int stall_phase;
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_phase <= 0;
         hold_cycles <= 0;
      end else begin
         stall_phase <= stall_phase + 1;
         if (stall_phase >= 300 && stall_phase < 400) begin
            hold_cycles <= hold_cycles + 1;
            rsp_stall <= 1'b1;
         end else if (stall_phase % 1000 < 200) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= (stall_phase % 7 == 3) || ($urandom_range(0, 3) == 0);
         end
      end
   end

   // Monitor: compare each response with the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (region_queue.size() == 0) begin
            report_mismatch("unexpected response", 1, 0);
         end else begin
            want = region_queue.pop_front();
            if (rsp_payload.kept_count !== want.kept_count)
               report_mismatch("kept_count", rsp_payload.kept_count, want.kept_count);
            if (rsp_payload.out_first_x !== want.out_first_x)
               report_mismatch("out_first_x", rsp_payload.out_first_x, want.out_first_x);
            if (rsp_payload.out_first_y !== want.out_first_y)
               report_mismatch("out_first_y", rsp_payload.out_first_y, want.out_first_y);
            if (rsp_payload.out_second_x !== want.out_second_x)
               report_mismatch("out_second_x", rsp_payload.out_second_x, want.out_second_x);
            if (rsp_payload.out_second_y !== want.out_second_y)
               report_mismatch("out_second_y", rsp_payload.out_second_y, want.out_second_y);
            if (rsp_payload.out_third_x !== want.out_third_x)
               report_mismatch("out_third_x", rsp_payload.out_third_x, want.out_third_x);
            if (rsp_payload.out_third_y !== want.out_third_y)
               report_mismatch("out_third_y", rsp_payload.out_third_y, want.out_third_y);
            if (rsp_payload.weight_first !== want.weight_first)
               report_mismatch("weight_first", rsp_payload.weight_first, want.weight_first);
            if (rsp_payload.weight_second !== want.weight_second)
               report_mismatch("weight_second", rsp_payload.weight_second, want.weight_second);
            if (rsp_payload.degenerate !== want.degenerate)
               report_mismatch("degenerate", rsp_payload.degenerate, want.degenerate);
         end
         checked_count++;
      end
   end

   // End of run: drain, settle, then report; a cycle limit guards against hangs.
   initial begin
      cycle_count = 0;
      deg_count = 0;
      interior_count = 0;
      burst_left = 0;
      gap_left = 0;
      @(negedge reset);
      while (!(feed_done && simplex_queue.size() == 0 && !req_valid &&
               region_queue.size() == 0)) begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
         end
      end
      repeat (2 * LATENCY) @(posedge clock);
      $display("checked %0d responses, %0d interior, %0d degenerate; long hold-off %0d cycles",
               checked_count, interior_count, deg_count, hold_cycles);
      if (mismatch_count == 0 && region_queue.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

>>> gjk_2d_simplex_closest_point.f
design/gjk_pkg.sv
design/gjk_prod.sv
design/gjk_region.sv
design/gjk_div.sv
design/gjk_2d_simplex_closest_point.sv
tb/tb_gjk_2d_simplex_closest_point.sv
